/* hw/rtl/flush_all_key_value_cache_top_macros.svh */
// Assertion macros for the key-value cache checker.
// Used by fkvc_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef FLUSH_ALL_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define FLUSH_ALL_KEY_VALUE_CACHE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FKVC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fkvc_pkg.sv */
// Shared types and constants for the key-value cache.
// No dependencies.
`default_nettype none
package fkvc_pkg;

    localparam logic [2:0] CMD_LOOKUP_VALUE = 3'd0;
    localparam logic [2:0] CMD_LOOKUP_SIZE  = 3'd1;
    localparam logic [2:0] CMD_INSERT_START = 3'd2;
    localparam logic [2:0] CMD_INSERT_WORD  = 3'd3;
    localparam logic [2:0] CMD_DROP         = 3'd4;

    localparam logic [1:0] STATUS_MISS       = 2'd0;
    localparam logic [1:0] STATUS_HIT        = 2'd1;
    localparam logic [1:0] STATUS_STORED     = 2'd2;
    localparam logic [1:0] STATUS_NOT_STORED = 2'd3;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [1:0] CFG_POOL_SIZE = 2'd2;

    localparam int HIT_OFF_W = 16;
    localparam int VLEN_W    = 10;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_STREAM = 3'b100
    } t_state;

    // Search result rippling down the cell row; first match sticks.
    typedef struct packed {
        logic                 found;
        logic [HIT_OFF_W-1:0] off;
        logic [VLEN_W-1:0]    vlen;
    } t_hit;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        if (n >= 4'd8) begin
            m = '1;
        end else begin
            m = (64'd1 << (6'(n) * 6'd8)) - 64'd1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/fkvc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/fkvc_cell.sv */
// One entry of the cache table: stored key and value location, a registered
// key match, and one link of the first-match chain. Uses fkvc_pkg.
`default_nettype none
module fkvc_cell #(
    parameter int KEY_W = 64,
    parameter int OFF_W = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_we,
    input  wire logic [KEY_W-1:0]      i_wr_key,
    input  wire logic [3:0]            i_wr_klen,
    input  wire logic [OFF_W-1:0]      i_wr_off,
    input  wire logic [9:0]            i_wr_vlen,
    input  wire logic                  i_cmp,
    input  wire logic [KEY_W-1:0]      i_cmp_key,
    input  wire logic [3:0]            i_cmp_klen,
    input  wire logic                  i_active,
    input  wire fkvc_pkg::t_hit        i_chain,
    output fkvc_pkg::t_hit             o_chain
);

    logic [KEY_W-1:0] r_key;
    logic [3:0]       r_klen;
    logic [OFF_W-1:0] r_off;
    logic [9:0]       r_vlen;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key  <= i_wr_key;
            r_klen <= i_wr_klen;
            r_off  <= i_wr_off;
            r_vlen <= i_wr_vlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp) begin
            r_match <= (r_klen == i_cmp_klen) && (r_key == i_cmp_key);
        end
    end

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.found && r_match && i_active) begin
            o_chain.found = 1'b1;
            o_chain.off   = fkvc_pkg::HIT_OFF_W'(r_off);
            o_chain.vlen  = r_vlen;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/flush_all_key_value_cache_top.sv */
// Key-value cache top level: command sequencer, entry cell row, byte-lane pool.
// Depends on fkvc_pkg, fkvc_cell and fkvc_ram.
//  - Commands: a transaction is taken at a rising edge with i_start high and
//    o_busy low; i_command selects lookup_value, lookup_size, insert_start,
//    insert_word or drop_if_present, other codes are ignored.
//  - Results: shown for exactly one cycle with o_valid high; the receiver
//    cannot stall, so nothing is held back. o_last marks a command's final one.
//  - Sequence: a command is compared across all entry cells at the accepting
//    edge and handled in the decide state; insert_word and unknown codes give
//    no result, a lookup_value hit with data streams words, and any other
//    single result is out in the cycle after the decide cycle. A stream keeps
//    o_busy high, one pool word read per cycle. A new command may start while
//    the last words drain through the lane RAM, pool stage and result registers.
//  - Configuration: i_cfg_we/i_cfg_index/i_cfg_data write cache_enabled (0),
//    capacity (1) and pool_size (2); write only while idle.
//  - Reset (synchronous, active low) empties the table, rewinds the pool,
//    cancels any pending insert and restores the register defaults; cells and
//    pool are not cleared since only committed entries are ever read.
//  - The pool is eight byte lanes: one eight-byte word per cycle at any offset.
`default_nettype none
module flush_all_key_value_cache_top #(
    parameter int MAX_ENTRIES     = 16,
    parameter int KEY_BYTES       = 8,
    parameter int POOL_BYTES      = 4096,
    parameter int MAX_VALUE_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [63:0] i_key,
    input  wire logic [3:0]  i_key_len,
    input  wire logic [9:0]  i_max_out,
    input  wire logic [9:0]  i_value_len,
    input  wire logic [63:0] i_in_word,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [9:0]       o_found_size,
    output logic [63:0]      o_out_word,
    output logic [3:0]       o_word_bytes,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int PUW  = $clog2(POOL_BYTES + 1);
    localparam int AW   = $clog2(POOL_BYTES);
    localparam int ROWS = POOL_BYTES / 8;
    localparam int ROWW = AW - 3;
    localparam int KW   = KEY_BYTES * 8;

    // config
    logic        r_en;
    logic [4:0]  r_capacity;
    logic [12:0] r_pool_size;

    // control state
    fkvc_pkg::t_state r_state, n_state;
    logic [CNTW-1:0]  r_count, n_count;
    logic [PUW-1:0]   r_used, n_used;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [9:0]       r_rem, n_rem;
    logic             r_drop, n_drop;

    // latched command
    logic [2:0]  r_cmd;
    logic [63:0] r_key;
    logic [3:0]  r_key_len;
    logic [9:0]  r_max_out;
    logic [9:0]  r_value_len;
    logic [63:0] r_in_word;

    // streaming
    logic [AW-1:0] r_addr, n_addr;
    logic [9:0]    r_left, n_left;
    logic [9:0]    r_size, n_size;
    logic          r_p_valid;
    logic [2:0]    r_p_rot;
    logic [3:0]    r_p_n;
    logic          r_p_last;

    // result register
    logic        r_valid, n_valid;
    logic [1:0]  r_status, n_status;
    logic [9:0]  r_vsize, n_vsize;
    logic [63:0] r_word, n_word;
    logic [3:0]  r_wbytes, n_wbytes;
    logic        r_last, n_last;

    logic accept;
    assign accept = i_start && (r_state == fkvc_pkg::S_IDLE);
    assign o_busy = (r_state != fkvc_pkg::S_IDLE);

    // ---------------- entry cell row ----------------
    logic [63:0]     cmp_key;
    logic [63:0]     wr_key;
    logic [CNTW-1:0] slot;
    logic            cell_we_any;
    fkvc_pkg::t_hit  chain [MAX_ENTRIES+1];

    assign cmp_key  = i_key & fkvc_pkg::byte_mask(i_key_len);
    assign wr_key   = r_key & fkvc_pkg::byte_mask(r_key_len);
    assign chain[0] = '0;

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        fkvc_cell #(
            .KEY_W (KW),
            .OFF_W (AW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_we       (cell_we_any && (slot == CNTW'(gi))),
            .i_wr_key   (wr_key[KW-1:0]),
            .i_wr_klen  (r_key_len),
            .i_wr_off   (AW'(n_ptr)),
            .i_wr_vlen  (r_value_len),
            .i_cmp      (accept),
            .i_cmp_key  (cmp_key[KW-1:0]),
            .i_cmp_klen (i_key_len),
            .i_active   (CNTW'(gi) < r_count),
            .i_chain    (chain[gi]),
            .o_chain    (chain[gi+1])
        );
    end

    // ---------------- byte-lane pool ----------------
    logic [3:0]      wr_n;
    logic            pool_we;
    logic [7:0]      lane_q [8];

    assign wr_n = (r_rem > 10'd8) ? 4'd8 : r_rem[3:0];

    for (genvar gl = 0; gl < 8; gl++) begin : g_lane
        logic [2:0]      wb;
        logic [ROWW-1:0] wrow;
        logic [ROWW-1:0] rrow;
        assign wb   = 3'(gl) - r_ptr[2:0];
        assign wrow = r_ptr[AW-1:3] + ROWW'(3'(gl) < r_ptr[2:0]);
        assign rrow = r_addr[AW-1:3] + ROWW'(3'(gl) < r_addr[2:0]);
        fkvc_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (pool_we && ({1'b0, wb} < wr_n)),
            .i_waddr (wrow),
            .i_wdata (r_in_word[8*wb +: 8]),
            .i_raddr (rrow),
            .o_rdata (lane_q[gl])
        );
    end

    // Rotate lanes back into value byte order and blank unused bytes.
    logic [63:0] rd_word;
    always_comb begin
        rd_word = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < r_p_n) begin
                rd_word[8*b +: 8] = lane_q[3'(r_p_rot + 3'(b))];
            end
        end
    end

    // ---------------- decide logic ----------------
    logic [CNTW-1:0] cap_eff;
    logic [PUW-1:0]  ep;
    logic            key_ok;
    logic            found;
    logic [9:0]      hit_len;
    logic            ins_bad;
    logic            full;
    logic [PUW-1:0]  used_a, used_b, free_a;
    logic [CNTW-1:0] cnt_a;
    logic            need_clr;
    logic            ins_ok;
    logic [3:0]      rd_n;

    always_comb begin
        if (r_capacity == 5'd0) begin
            cap_eff = CNTW'(1);
        end else if (32'(r_capacity) > MAX_ENTRIES) begin
            cap_eff = CNTW'(MAX_ENTRIES);
        end else begin
            cap_eff = CNTW'(r_capacity);
        end
        ep = (32'(r_pool_size) > POOL_BYTES) ? PUW'(POOL_BYTES) : PUW'(r_pool_size);
    end

    assign key_ok  = (32'(r_key_len) <= KEY_BYTES);
    assign found   = chain[MAX_ENTRIES].found && r_en && key_ok;
    assign hit_len = chain[MAX_ENTRIES].vlen;

    // insert_start: clear on full table, then clear-and-retry on short pool
    assign ins_bad  = !r_en || !key_ok || (32'(r_value_len) > MAX_VALUE_BYTES);
    assign full     = (r_count >= cap_eff);
    assign used_a   = full ? '0 : r_used;
    assign cnt_a    = full ? '0 : r_count;
    assign free_a   = (used_a >= ep) ? '0 : (ep - used_a);
    assign need_clr = (32'(free_a) < 32'(r_value_len));
    assign used_b   = need_clr ? '0 : used_a;
    assign slot     = need_clr ? '0 : cnt_a;
    assign ins_ok   = (!need_clr || (32'(ep) >= 32'(r_value_len)))
                      && (32'(slot) < MAX_ENTRIES);

    assign cell_we_any = (r_state == fkvc_pkg::S_DECIDE)
                         && (r_cmd == fkvc_pkg::CMD_INSERT_START) && !ins_bad && ins_ok;
    assign pool_we     = (r_state == fkvc_pkg::S_DECIDE)
                         && (r_cmd == fkvc_pkg::CMD_INSERT_WORD)
                         && (r_rem != 10'd0) && !r_drop;

    assign rd_n = (r_left > 10'd8) ? 4'd8 : r_left[3:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_used   = r_used;
        n_ptr    = r_ptr;
        n_rem    = r_rem;
        n_drop   = r_drop;
        n_addr   = r_addr;
        n_left   = r_left;
        n_size   = r_size;
        n_valid  = 1'b0;
        n_status = fkvc_pkg::STATUS_MISS;
        n_vsize  = '0;
        n_word   = '0;
        n_wbytes = '0;
        n_last   = 1'b1;

        case (r_state)
            fkvc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = fkvc_pkg::S_DECIDE;
                end
            end
            fkvc_pkg::S_DECIDE: begin
                n_state = fkvc_pkg::S_IDLE;
                case (r_cmd)
                    fkvc_pkg::CMD_LOOKUP_VALUE, fkvc_pkg::CMD_LOOKUP_SIZE: begin
                        n_valid = 1'b1;
                        if (found && !(r_cmd == fkvc_pkg::CMD_LOOKUP_VALUE
                                       && hit_len > r_max_out)) begin
                            if (r_cmd == fkvc_pkg::CMD_LOOKUP_SIZE || hit_len == 10'd0) begin
                                n_status = fkvc_pkg::STATUS_HIT;
                                n_vsize  = hit_len;
                            end else begin
                                // results come from the streaming pipeline
                                n_valid = 1'b0;
                                n_state = fkvc_pkg::S_STREAM;
                                n_addr  = AW'(chain[MAX_ENTRIES].off);
                                n_left  = hit_len;
                                n_size  = hit_len;
                            end
                        end
                    end
                    fkvc_pkg::CMD_INSERT_START: begin
                        n_valid  = 1'b1;
                        n_status = fkvc_pkg::STATUS_NOT_STORED;
                        n_rem    = r_value_len;
                        n_drop   = 1'b1;
                        if (!ins_bad) begin
                            n_used  = used_b;
                            n_count = slot;
                            if (ins_ok) begin
                                n_status = fkvc_pkg::STATUS_STORED;
                                n_ptr    = AW'(used_b);
                                n_used   = used_b + PUW'(r_value_len);
                                n_drop   = 1'b0;
                                if (r_value_len == 10'd0) begin
                                    n_count = slot + CNTW'(1);
                                end
                            end
                        end
                    end
                    fkvc_pkg::CMD_INSERT_WORD: begin
                        if (r_rem != 10'd0) begin
                            n_ptr = r_ptr + AW'(wr_n);
                            n_rem = r_rem - 10'(wr_n);
                            if (r_rem <= 10'd8) begin
                                if (!r_drop && (32'(r_count) < MAX_ENTRIES)) begin
                                    n_count = r_count + CNTW'(1);
                                end
                                n_drop = 1'b0;
                            end
                        end
                    end
                    fkvc_pkg::CMD_DROP: begin
                        n_valid = 1'b1;
                        if (found) begin
                            n_status = fkvc_pkg::STATUS_HIT;
                            n_used   = '0;
                            n_count  = '0;
                            if (r_rem != 10'd0) begin
                                n_drop = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            fkvc_pkg::S_STREAM: begin
                n_addr = r_addr + AW'(rd_n);
                n_left = r_left - 10'(rd_n);
                if (r_left <= 10'd8) begin
                    n_state = fkvc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fkvc_pkg::S_IDLE;
            end
        endcase

        // word arriving from the pool; never collides with a decide result
        if (r_p_valid) begin
            n_valid  = 1'b1;
            n_status = fkvc_pkg::STATUS_HIT;
            n_vsize  = r_size;
            n_word   = rd_word;
            n_wbytes = r_p_n;
            n_last   = r_p_last;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fkvc_pkg::S_IDLE;
            r_count     <= '0;
            r_used      <= '0;
            r_ptr       <= '0;
            r_rem       <= '0;
            r_drop      <= 1'b0;
            r_p_valid   <= 1'b0;
            r_valid     <= 1'b0;
            r_en        <= 1'b0;
            r_capacity  <= 5'd16;
            r_pool_size <= 13'd4096;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_used    <= n_used;
            r_ptr     <= n_ptr;
            r_rem     <= n_rem;
            r_drop    <= n_drop;
            r_p_valid <= (r_state == fkvc_pkg::S_STREAM);
            r_valid   <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fkvc_pkg::CFG_ENABLE:    r_en        <= i_cfg_data[0];
                    fkvc_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data[4:0];
                    fkvc_pkg::CFG_POOL_SIZE: r_pool_size <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_command;
            r_key       <= i_key;
            r_key_len   <= i_key_len;
            r_max_out   <= i_max_out;
            r_value_len <= i_value_len;
            r_in_word   <= i_in_word;
        end
        r_addr   <= n_addr;
        r_left   <= n_left;
        r_size   <= n_size;
        r_p_rot  <= r_addr[2:0];
        r_p_n    <= rd_n;
        r_p_last <= (r_left <= 10'd8);
        r_status <= n_status;
        r_vsize  <= n_vsize;
        r_word   <= n_word;
        r_wbytes <= n_wbytes;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_found_size = r_vsize;
    assign o_out_word   = r_word;
    assign o_word_bytes = r_wbytes;
    assign o_last       = r_last;

endmodule
`default_nettype wire

/* hw/rtl/fkvc_checker.sv */
// Port-level checks for the key-value cache, bound to the top level.
// Uses fkvc_pkg and flush_all_key_value_cache_top_macros.svh.
`default_nettype none
`include "flush_all_key_value_cache_top_macros.svh"
module fkvc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        i_busy,
    input wire logic        i_valid,
    input wire logic [1:0]  i_status,
    input wire logic [63:0] i_out_word,
    input wire logic [3:0]  i_word_bytes,
    input wire logic        i_last
);

    `FKVC_ASSERT_NEXT(a_accept_busy, i_start && !i_busy, i_busy, "no busy after accepted transaction")
    `FKVC_ASSERT_SAME(a_insert_single, i_valid && (i_status == fkvc_pkg::STATUS_STORED || i_status == fkvc_pkg::STATUS_NOT_STORED), i_last, "insert answer not single")
    `FKVC_ASSERT_SAME(a_miss_clean, i_valid && i_status == fkvc_pkg::STATUS_MISS, i_last && i_out_word == 64'd0 && i_word_bytes == 4'd0, "miss carries data")
    `FKVC_ASSERT_SAME(a_mid_full, i_valid && !i_last, i_status == fkvc_pkg::STATUS_HIT && i_word_bytes == 4'd8, "partial word before last")
    `FKVC_ASSERT_NEXT(a_stream_gapless, i_valid && !i_last, i_valid, "gap in value stream")

endmodule

bind flush_all_key_value_cache_top fkvc_checker u_fkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .i_busy       (o_busy),
    .i_valid      (o_valid),
    .i_status     (o_status),
    .i_out_word   (o_out_word),
    .i_word_bytes (o_word_bytes),
    .i_last       (o_last)
);
`default_nettype wire

/* tb/flush_all_key_value_cache_top_tb.sv */
// Self-checking testbench for the key-value cache top level.
// Depends on fkvc_pkg and flush_all_key_value_cache_top; holds its own cache predictor.
`default_nettype none
module flush_all_key_value_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // index past the last register
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         NUM_KEYS = 6;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  size;
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_result;

    // Cache predictor plus queue of results still owed by the block.
    class kv_scoreboard;
        logic [63:0] ent_key[16];
        logic [3:0]  ent_klen[16];
        int          ent_off[16];
        int          ent_vlen[16];
        int          ent_count, pool_used, wr_ptr, wr_left;
        bit          wr_drop;
        byte unsigned pool[4096];
        bit          enabled;
        int          cap_reg, pool_reg;
        t_result     owed[$];
        int          errors;

        function void reset_state();
            ent_count = 0; pool_used = 0; wr_ptr = 0; wr_left = 0; wr_drop = 0;
            enabled = 0; cap_reg = 16; pool_reg = 4096; errors = 0;
            foreach (pool[i]) pool[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                fkvc_pkg::CFG_ENABLE:    enabled = data[0];
                fkvc_pkg::CFG_CAPACITY:  cap_reg = int'(data[4:0]);
                fkvc_pkg::CFG_POOL_SIZE: pool_reg = int'(data);
                default: ;
            endcase
        endfunction

        function logic [63:0] key_mask(int n);
            return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        function int lookup(logic [63:0] key, logic [3:0] klen);
            if (!enabled || klen > 8) return -1;
            for (int i = 0; i < ent_count && i < 16; i++)
                if (ent_klen[i] == klen && ((ent_key[i] ^ key) & key_mask(klen)) == 0)
                    return i;
            return -1;
        endfunction

        function void flush();
            pool_used = 0;
            ent_count = 0;
            if (wr_left > 0) wr_drop = 1;
        endfunction

        function int free_bytes();
            int lim;
            lim = (pool_reg > 4096) ? 4096 : pool_reg;
            return (pool_used >= lim) ? 0 : lim - pool_used;
        endfunction

        function void owe(logic [1:0] st, int sz, logic [63:0] w, int nb, bit l);
            owed.push_back('{st, 10'(sz), w, 4'(nb), l});
        endfunction

        // Accepted command transaction: update model, queue its results.
        function void note_command(logic [2:0] cmd, logic [63:0] key, logic [3:0] klen,
                                   logic [9:0] max_out, logic [9:0] vlen, logic [63:0] word);
            int idx, len, done, n, lim;
            logic [63:0] w;
            case (cmd)
                fkvc_pkg::CMD_LOOKUP_VALUE, fkvc_pkg::CMD_LOOKUP_SIZE: begin
                    idx = lookup(key, klen);
                    if (idx < 0 || (cmd == fkvc_pkg::CMD_LOOKUP_VALUE
                                    && ent_vlen[idx] > max_out)) begin
                        owe(fkvc_pkg::STATUS_MISS, 0, 0, 0, 1);
                    end else if (cmd == fkvc_pkg::CMD_LOOKUP_SIZE || ent_vlen[idx] == 0) begin
                        owe(fkvc_pkg::STATUS_HIT, ent_vlen[idx], 0, 0, 1);
                    end else begin
                        len = ent_vlen[idx];
                        done = 0;
                        while (done < len) begin
                            n = (len - done > 8) ? 8 : len - done;
                            w = 0;
                            for (int b = 0; b < n; b++)
                                w[8*b +: 8] = pool[ent_off[idx] + done + b];
                            done += n;
                            owe(fkvc_pkg::STATUS_HIT, len, w, n, done >= len);
                        end
                    end
                end
                fkvc_pkg::CMD_INSERT_START: begin
                    lim = (cap_reg == 0) ? 1 : (cap_reg > 16 ? 16 : cap_reg);
                    wr_left = vlen;
                    wr_drop = 1;
                    if (!enabled || klen > 8 || vlen > 512) begin
                        owe(fkvc_pkg::STATUS_NOT_STORED, 0, 0, 0, 1);
                        return;
                    end
                    if (ent_count >= lim) flush();
                    if (free_bytes() < vlen) begin
                        flush();
                        if (free_bytes() < vlen) begin
                            owe(fkvc_pkg::STATUS_NOT_STORED, 0, 0, 0, 1);
                            return;
                        end
                    end
                    ent_key[ent_count]  = key & key_mask(klen);
                    ent_klen[ent_count] = klen;
                    ent_off[ent_count]  = pool_used;
                    ent_vlen[ent_count] = vlen;
                    wr_ptr = pool_used;
                    pool_used += vlen;
                    wr_drop = 0;
                    if (vlen == 0) ent_count++;
                    owe(fkvc_pkg::STATUS_STORED, 0, 0, 0, 1);
                end
                fkvc_pkg::CMD_INSERT_WORD: begin
                    if (wr_left == 0) return;   // stray word
                    n = (wr_left > 8) ? 8 : wr_left;
                    if (!wr_drop)
                        for (int b = 0; b < n; b++)
                            if (wr_ptr + b < 4096) pool[wr_ptr + b] = word[8*b +: 8];
                    wr_ptr += n;
                    wr_left -= n;
                    if (wr_left == 0) begin
                        if (!wr_drop && ent_count < 16) ent_count++;
                        wr_drop = 0;
                    end
                end
                fkvc_pkg::CMD_DROP: begin
                    idx = lookup(key, klen);
                    if (idx >= 0) begin
                        flush();
                        owe(fkvc_pkg::STATUS_HIT, 0, 0, 0, 1);
                    end else begin
                        owe(fkvc_pkg::STATUS_MISS, 0, 0, 0, 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (owed.size() == 0) begin
                $error("unexpected result status %0d", got.status);
                errors++;
                return;
            end
            exp = owed.pop_front();
            if (got.status !== exp.status) begin
                $error("status exp %0h act %0h", exp.status, got.status); errors++;
            end
            if (got.size !== exp.size) begin
                $error("found_size exp %0h act %0h", exp.size, got.size); errors++;
            end
            if (got.word !== exp.word) begin
                $error("out_word exp %0h act %0h", exp.word, got.word); errors++;
            end
            if (got.nbytes !== exp.nbytes) begin
                $error("word_bytes exp %0h act %0h", exp.nbytes, got.nbytes); errors++;
            end
            if (got.last !== exp.last) begin
                $error("last exp %0h act %0h", exp.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        o_busy;
    logic [2:0]  i_command = '0;
    logic [63:0] i_key = '0;
    logic [3:0]  i_key_len = '0;
    logic [9:0]  i_max_out = '0;
    logic [9:0]  i_value_len = '0;
    logic [63:0] i_in_word = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [9:0]  o_found_size;
    logic [63:0] o_out_word;
    logic [3:0]  o_word_bytes;
    logic        o_last;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    kv_scoreboard cache_sb;
    int           cycles = 0;
    bit           no_gaps = 0;      // set for back-to-back stretches
    logic [63:0]  key_set[NUM_KEYS];
    logic [3:0]   klen_set[NUM_KEYS];

    flush_all_key_value_cache_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Results cannot be stalled: every strobe is checked on the edge it ends on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            cache_sb.check_result('{o_status, o_found_size, o_out_word, o_word_bytes, o_last});
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One command transaction. Inputs move on the falling edge; busy is stable
    // there, so the accepting edge is known in advance.
    task automatic send(logic [2:0] cmd, logic [63:0] key, logic [3:0] klen,
                        logic [9:0] max_out, logic [9:0] vlen, logic [63:0] word);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_start = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_command = cmd; i_key = key; i_key_len = klen;
        i_max_out = max_out; i_value_len = vlen; i_in_word = word;
        i_start = 1;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        cache_sb.note_command(cmd, key, klen, max_out, vlen, word);
        @(negedge i_clk);
    endtask

    // Let the pipeline drain: all owed results in, plus settling time.
    task automatic drain();
        i_start = 0;
        while (cache_sb.owed.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        i_cfg_we = 1; i_cfg_index = idx; i_cfg_data = data;
        @(posedge i_clk);
        cache_sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Full insert: start plus the words that carry its bytes; a cut one sends
    // at most two of them.
    task automatic insert_value(logic [63:0] key, logic [3:0] klen, int vlen, bit cut);
        int words;
        send(fkvc_pkg::CMD_INSERT_START, key, klen, 10'($urandom), 10'(vlen),
             {$urandom, $urandom});
        words = (vlen + 7) / 8;
        if (cut && words > 0) words = $urandom_range(0, ((words > 3) ? 3 : words) - 1);
        for (int i = 0; i < words; i++)
            send(fkvc_pkg::CMD_INSERT_WORD, {$urandom, $urandom}, 4'($urandom),
                 10'($urandom), 10'($urandom), {$urandom, $urandom});
    endtask

    task automatic random_item();
        int k, pick, vlen;
        bit cut;
        logic [63:0] key;
        logic [3:0]  klen;
        logic [9:0]  mo;
        k = $urandom_range(0, NUM_KEYS - 1);
        key = key_set[k] ^ ({$urandom, $urandom} & ~cache_sb.key_mask(klen_set[k]));
        klen = klen_set[k];
        if ($urandom_range(0, 15) == 0) begin
            key = {$urandom, $urandom};
            klen = 4'($urandom);
        end
        mo = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd512;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            cut = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    vlen = $urandom_range(513, 1023);
                    cut  = 1'b1;
                end
                default: vlen = $urandom_range(0, 40);
            endcase
            insert_value(key, klen, vlen, cut);
        end else if (pick < 70) begin
            send(fkvc_pkg::CMD_LOOKUP_VALUE, key, klen, mo, 10'($urandom),
                 {$urandom, $urandom});
        end else if (pick < 82) begin
            send(fkvc_pkg::CMD_LOOKUP_SIZE, key, klen, 10'($urandom), 10'($urandom),
                 {$urandom, $urandom});
        end else if (pick < 92) begin
            send(fkvc_pkg::CMD_DROP, key, klen, 10'($urandom), 10'($urandom),
                 {$urandom, $urandom});
        end else if (pick < 96) begin
            send(fkvc_pkg::CMD_INSERT_WORD, key, klen, 10'($urandom), 10'($urandom),
                 {$urandom, $urandom});
        end else begin
            send(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), key, klen, 10'($urandom),
                 10'($urandom), {$urandom, $urandom});
        end
    endtask

    initial begin
        logic [63:0] k8;
        int caps[5];
        int pools[5];
        cache_sb = new();
        cache_sb.reset_state();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Disabled after reset: lookups miss, inserts are refused.
        k8 = {$urandom, $urandom};
        send(fkvc_pkg::CMD_LOOKUP_VALUE, k8, 4'd8, 10'd512, 10'd0, 64'd0);
        insert_value(k8, 4'd8, 8, 0);
        send(fkvc_pkg::CMD_DROP, k8, 4'd8, 10'd0, 10'd0, 64'd0);
        drain();
        write_reg(fkvc_pkg::CFG_ENABLE, 13'd1);
        write_reg(CFG_UNUSED, 13'h1FFF);

        // Directed: normal hits, size limits, bad lengths, empty value, drops.
        insert_value(k8, 4'd8, 20, 0);
        send(fkvc_pkg::CMD_LOOKUP_VALUE, k8, 4'd8, 10'd512, 10'd0, 64'd0);
        send(fkvc_pkg::CMD_LOOKUP_VALUE, k8, 4'd8, 10'd19, 10'd0, 64'd0); // too big for max_out
        send(fkvc_pkg::CMD_LOOKUP_SIZE, k8, 4'd8, 10'd0, 10'd0, 64'd0);
        send(fkvc_pkg::CMD_LOOKUP_VALUE, k8, 4'd15, 10'h3FF, 10'd0, 64'd0); // key too long
        insert_value(k8, 4'd9, 8, 0);
        insert_value(64'd0, 4'd0, 513, 1);                                   // value too long
        insert_value('1, 4'd0, 0, 0);                                        // empty key and value
        send(fkvc_pkg::CMD_LOOKUP_VALUE, '1, 4'd0, 10'd0, 10'd0, 64'd0);
        insert_value('1, 4'd3, 512, 0);
        send(fkvc_pkg::CMD_LOOKUP_VALUE, 64'hFF_FFFF, 4'd3, 10'h3FF, 10'h3FF, '1);
        send(fkvc_pkg::CMD_INSERT_WORD, '1, 4'hF, '1, '1, '1);              // stray word
        send(CMD_BAD_LO, '1, 4'hF, '1, '1, '1);
        send(CMD_BAD_HI, 64'd0, 4'd0, 10'd0, 10'd0, 64'd0);
        send(fkvc_pkg::CMD_INSERT_START, k8, 4'd2, 10'd0, 10'd24, 64'd0);
        send(fkvc_pkg::CMD_INSERT_START, k8, 4'd1, 10'd0, 10'd4, 64'd0);   // abandons previous
        send(fkvc_pkg::CMD_INSERT_WORD, 64'd0, 4'd0, 10'd0, 10'd0, '1);
        send(fkvc_pkg::CMD_DROP, k8, 4'd8, 10'd0, 10'd0, 64'd0);
        send(fkvc_pkg::CMD_DROP, k8, 4'd8, 10'd0, 10'd0, 64'd0);
        send(fkvc_pkg::CMD_LOOKUP_SIZE, k8, 4'd1, 10'd0, 10'd0, 64'd0);
        drain();

        // Random phases across register settings, extremes included.
        caps  = '{16, 2, 0, 31, 1};
        pools = '{4096, 100, 0, 8191, 600};
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_set[i]  = {$urandom, $urandom};
            klen_set[i] = (i < 2) ? 4'd8 : 4'($urandom_range(0, 8));
        end
        key_set[1] = key_set[0] ^ 64'hFF00_0000_0000_0000;  // differs only in the top byte
        klen_set[1] = 4'd7;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(fkvc_pkg::CFG_CAPACITY, 13'(caps[ph]));
            write_reg(fkvc_pkg::CFG_POOL_SIZE, 13'(pools[ph]));
            for (int n = 0; n < 4; n++) begin
                no_gaps = (ph == 1) || (n >= 2);
                random_item();
                if (ph == 2 && n == 1) begin
                    // hold off until the block has delivered everything owed
                    i_start = 0;
                    while (cache_sb.owed.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end
        write_reg(fkvc_pkg::CFG_ENABLE, 13'd0);
        for (int n = 0; n < 2; n++) random_item();
        drain();

        repeat (20) @(posedge i_clk);
        if (cache_sb.errors == 0 && cache_sb.owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* flush_all_key_value_cache_top.f */
+incdir+hw/rtl
hw/rtl/fkvc_pkg.sv
hw/rtl/fkvc_ram.sv
hw/rtl/fkvc_cell.sv
hw/rtl/flush_all_key_value_cache_top.sv
hw/rtl/fkvc_checker.sv
tb/flush_all_key_value_cache_top_tb.sv
